// File: rtl/ceu_pkg.sv
// shared types and decode constants for the 6502 execute unit
package ceu_pkg;

	// input item: opcode and the operand byte already fetched
	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] mem_data;
	} ceu_item_t;

	// result item: memory side effects, branch decision and new registers
	typedef struct packed {
		logic [7:0] write_data;
		logic       write_enable;
		logic [7:0] stack_addr_low;
		logic       branch_taken;
		logic [7:0] acc_out;
		logic [7:0] x_out;
		logic [7:0] y_out;
		logic [7:0] sp_out;
		logic [7:0] status_out;
	} ceu_result_t;

	// status bit positions, NV-BDIZC
	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_I = 2;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_B = 4;
	localparam int unsigned FLAG_U = 5;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	// register values after reset
	localparam logic [7:0] SP_RESET     = 8'hFD;
	localparam logic [7:0] STATUS_RESET = 8'h24;

	// opcode group, bits [1:0]
	localparam logic [1:0] CC_CTL = 2'b00;
	localparam logic [1:0] CC_ALU = 2'b01;
	localparam logic [1:0] CC_RMW = 2'b10;

	// operation, bits [7:5], alu group
	localparam logic [2:0] AAA_ORA = 3'b000;
	localparam logic [2:0] AAA_AND = 3'b001;
	localparam logic [2:0] AAA_EOR = 3'b010;
	localparam logic [2:0] AAA_ADC = 3'b011;
	localparam logic [2:0] AAA_STA = 3'b100;
	localparam logic [2:0] AAA_LDA = 3'b101;
	localparam logic [2:0] AAA_CMP = 3'b110;
	localparam logic [2:0] AAA_SBC = 3'b111;

	// operation, bits [7:5], read-modify-write group
	localparam logic [2:0] AAA_ASL = 3'b000;
	localparam logic [2:0] AAA_ROL = 3'b001;
	localparam logic [2:0] AAA_LSR = 3'b010;
	localparam logic [2:0] AAA_ROR = 3'b011;
	localparam logic [2:0] AAA_STX = 3'b100;
	localparam logic [2:0] AAA_LDX = 3'b101;
	localparam logic [2:0] AAA_DEC = 3'b110;
	localparam logic [2:0] AAA_INC = 3'b111;

	// operation, bits [7:5], control group
	localparam logic [2:0] AAA_BIT = 3'b001;
	localparam logic [2:0] AAA_STY = 3'b100;
	localparam logic [2:0] AAA_LDY = 3'b101;
	localparam logic [2:0] AAA_CPY = 3'b110;
	localparam logic [2:0] AAA_CPX = 3'b111;

	// single-byte control ops at mode IMPL, selected by bits [7:5]
	localparam logic [2:0] IMP_PHP = 3'b000;
	localparam logic [2:0] IMP_PLP = 3'b001;
	localparam logic [2:0] IMP_PHA = 3'b010;
	localparam logic [2:0] IMP_PLA = 3'b011;
	localparam logic [2:0] IMP_DEY = 3'b100;
	localparam logic [2:0] IMP_TAY = 3'b101;
	localparam logic [2:0] IMP_INY = 3'b110;
	localparam logic [2:0] IMP_INX = 3'b111;

	// single-byte control ops at mode IMPL2, selected by bits [7:5]
	localparam logic [2:0] FLG_CLC = 3'b000;
	localparam logic [2:0] FLG_SEC = 3'b001;
	localparam logic [2:0] FLG_CLI = 3'b010;
	localparam logic [2:0] FLG_SEI = 3'b011;
	localparam logic [2:0] FLG_TYA = 3'b100;
	localparam logic [2:0] FLG_CLV = 3'b101;
	localparam logic [2:0] FLG_CLD = 3'b110;
	localparam logic [2:0] FLG_SED = 3'b111;

	// address mode, bits [4:2]
	localparam logic [2:0] BBB_IMM0   = 3'b000;
	localparam logic [2:0] BBB_ZP     = 3'b001;
	localparam logic [2:0] BBB_IMPL   = 3'b010;
	localparam logic [2:0] BBB_ABS    = 3'b011;
	localparam logic [2:0] BBB_BRANCH = 3'b100;
	localparam logic [2:0] BBB_ZPX    = 3'b101;
	localparam logic [2:0] BBB_IMPL2  = 3'b110;
	localparam logic [2:0] BBB_ABSX   = 3'b111;

	// branch condition flag, bits [7:6]
	localparam logic [1:0] BR_N = 2'b00;
	localparam logic [1:0] BR_V = 2'b01;
	localparam logic [1:0] BR_C = 2'b10;
	localparam logic [1:0] BR_Z = 2'b11;

endpackage

// File: rtl/cpu6502_execute_unit_top.sv
// 6502 execute stage: registers, flag logic and result register
// Takes one instruction per clock when the result side keeps up. The opcode and
// operand are captured in an input register; from there the whole instruction
// is decoded and executed in one pass of 8-bit logic against A, X, Y, SP and
// P, which update in the same edge that loads the result register, so each
// instruction passes through the input register and then the result register.
// A result that waits holds the input register, which then holds off the next
// transfer. Each result carries the register file after the instruction, so
// consecutive items see each other's effects with no gap. Arithmetic is always
// binary; address modes, program counter and jumps are handled outside this
// block.
module cpu6502_execute_unit_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ceu_pkg::ceu_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ceu_pkg::ceu_result_t result
);

	logic                 valid_s1;
	ceu_pkg::ceu_item_t   item_s1;
	logic                 result_valid_q;
	ceu_pkg::ceu_result_t result_q;
	logic [7:0]           a_q, x_q, y_q, sp_q, p_q;
	logic                 advance;

	logic [7:0] a_n, x_n, y_n, sp_n, p_n;
	logic [7:0] wdata, saddr;
	logic       wen, taken;

	logic [7:0] m;
	logic [2:0] aaa, bbb;
	logic [1:0] cc;
	logic [7:0] addend;
	logic [8:0] sum;
	logic [7:0] cmp_reg;
	logic [8:0] diff;
	logic [7:0] sh_src, sh_res;
	logic       sh_cout;
	logic       br_flag;

	// handshake: execute when the result register is free or being drained
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// opcode fields
	assign m   = item_s1.mem_data;
	assign aaa = item_s1.opcode[7:5];
	assign bbb = item_s1.opcode[4:2];
	assign cc  = item_s1.opcode[1:0];

	// adc/sbc adder, sbc adds the inverted operand
	assign addend = (aaa == ceu_pkg::AAA_SBC) ? ~m : m;
	assign sum    = {1'b0, a_q} + {1'b0, addend} + {8'd0, p_q[ceu_pkg::FLAG_C]};

	// compare subtractor, carry out means register >= operand
	always_comb begin
		if (cc == ceu_pkg::CC_ALU) begin
			cmp_reg = a_q;
		end else if (aaa == ceu_pkg::AAA_CPX) begin
			cmp_reg = x_q;
		end else begin
			cmp_reg = y_q;
		end
	end
	assign diff = {1'b0, cmp_reg} + {1'b0, ~m} + 9'd1;

	// shifter for accumulator or memory operand
	assign sh_src = (bbb == ceu_pkg::BBB_IMPL) ? a_q : m;
	always_comb begin
		case (aaa[1:0])
			2'b00: begin
				sh_res  = {sh_src[6:0], 1'b0};
				sh_cout = sh_src[7];
			end
			2'b01: begin
				sh_res  = {sh_src[6:0], p_q[ceu_pkg::FLAG_C]};
				sh_cout = sh_src[7];
			end
			2'b10: begin
				sh_res  = {1'b0, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
			default: begin
				sh_res  = {p_q[ceu_pkg::FLAG_C], sh_src[7:1]};
				sh_cout = sh_src[0];
			end
		endcase
	end

	// branch condition flag
	always_comb begin
		unique case (item_s1.opcode[7:6])
			ceu_pkg::BR_N: br_flag = p_q[ceu_pkg::FLAG_N];
			ceu_pkg::BR_V: br_flag = p_q[ceu_pkg::FLAG_V];
			ceu_pkg::BR_C: br_flag = p_q[ceu_pkg::FLAG_C];
			default:       br_flag = p_q[ceu_pkg::FLAG_Z];
		endcase
	end

	// instruction decode and execute
	always_comb begin
		logic [7:0] nz_val;
		logic       nz_en;
		a_n    = a_q;
		x_n    = x_q;
		y_n    = y_q;
		sp_n   = sp_q;
		p_n    = p_q;
		wdata  = 8'd0;
		wen    = 1'b0;
		saddr  = 8'd0;
		taken  = 1'b0;
		nz_val = 8'd0;
		nz_en  = 1'b0;
		unique case (cc)
			ceu_pkg::CC_ALU: begin
				unique case (aaa) inside
					ceu_pkg::AAA_ORA: begin
						a_n = a_q | m; nz_val = a_n; nz_en = 1'b1;
					end
					ceu_pkg::AAA_AND: begin
						a_n = a_q & m; nz_val = a_n; nz_en = 1'b1;
					end
					ceu_pkg::AAA_EOR: begin
						a_n = a_q ^ m; nz_val = a_n; nz_en = 1'b1;
					end
					ceu_pkg::AAA_ADC, ceu_pkg::AAA_SBC: begin
						a_n = sum[7:0];
						p_n[ceu_pkg::FLAG_C] = sum[8];
						p_n[ceu_pkg::FLAG_V] = ~(a_q[7] ^ addend[7]) & (a_q[7] ^ sum[7]);
						nz_val = sum[7:0]; nz_en = 1'b1;
					end
					ceu_pkg::AAA_STA: begin
						if (bbb != ceu_pkg::BBB_IMPL) begin
							wdata = a_q; wen = 1'b1;
						end
					end
					ceu_pkg::AAA_LDA: begin
						a_n = m; nz_val = m; nz_en = 1'b1;
					end
					default: begin
						p_n[ceu_pkg::FLAG_C] = diff[8];
						nz_val = diff[7:0]; nz_en = 1'b1;
					end
				endcase
			end
			ceu_pkg::CC_RMW: begin
				unique case (aaa) inside
					ceu_pkg::AAA_ASL, ceu_pkg::AAA_ROL,
					ceu_pkg::AAA_LSR, ceu_pkg::AAA_ROR: begin
						if (bbb == ceu_pkg::BBB_IMPL) begin
							a_n = sh_res;
							p_n[ceu_pkg::FLAG_C] = sh_cout;
							nz_val = sh_res; nz_en = 1'b1;
						end else if (bbb inside {ceu_pkg::BBB_ZP, ceu_pkg::BBB_ABS,
								ceu_pkg::BBB_ZPX, ceu_pkg::BBB_ABSX}) begin
							wdata = sh_res; wen = 1'b1;
							p_n[ceu_pkg::FLAG_C] = sh_cout;
							nz_val = sh_res; nz_en = 1'b1;
						end
					end
					ceu_pkg::AAA_STX: begin
						if (bbb inside {ceu_pkg::BBB_ZP, ceu_pkg::BBB_ABS,
								ceu_pkg::BBB_ZPX}) begin
							wdata = x_q; wen = 1'b1;
						end else if (bbb == ceu_pkg::BBB_IMPL) begin
							// txa
							a_n = x_q; nz_val = x_q; nz_en = 1'b1;
						end else if (bbb == ceu_pkg::BBB_IMPL2) begin
							// txs leaves the flags alone
							sp_n = x_q;
						end
					end
					ceu_pkg::AAA_LDX: begin
						if (bbb inside {ceu_pkg::BBB_IMM0, ceu_pkg::BBB_ZP,
								ceu_pkg::BBB_ABS, ceu_pkg::BBB_ZPX, ceu_pkg::BBB_ABSX}) begin
							x_n = m; nz_val = m; nz_en = 1'b1;
						end else if (bbb == ceu_pkg::BBB_IMPL) begin
							// tax
							x_n = a_q; nz_val = a_q; nz_en = 1'b1;
						end else if (bbb == ceu_pkg::BBB_IMPL2) begin
							// tsx
							x_n = sp_q; nz_val = sp_q; nz_en = 1'b1;
						end
					end
					ceu_pkg::AAA_DEC: begin
						if (bbb inside {ceu_pkg::BBB_ZP, ceu_pkg::BBB_ABS,
								ceu_pkg::BBB_ZPX, ceu_pkg::BBB_ABSX}) begin
							wdata = m - 8'd1; wen = 1'b1;
							nz_val = wdata; nz_en = 1'b1;
						end else if (bbb == ceu_pkg::BBB_IMPL) begin
							// dex
							x_n = x_q - 8'd1; nz_val = x_n; nz_en = 1'b1;
						end
					end
					default: begin
						// inc; the implied slot here is nop
						if (bbb inside {ceu_pkg::BBB_ZP, ceu_pkg::BBB_ABS,
								ceu_pkg::BBB_ZPX, ceu_pkg::BBB_ABSX}) begin
							wdata = m + 8'd1; wen = 1'b1;
							nz_val = wdata; nz_en = 1'b1;
						end
					end
				endcase
			end
			ceu_pkg::CC_CTL: begin
				if (bbb == ceu_pkg::BBB_BRANCH) begin
					taken = (br_flag == item_s1.opcode[5]);
				end else if (bbb == ceu_pkg::BBB_IMPL) begin
					unique case (aaa)
						ceu_pkg::IMP_PHP: begin
							wdata = p_q;
							wdata[ceu_pkg::FLAG_B] = 1'b1;
							wdata[ceu_pkg::FLAG_U] = 1'b1;
							wen = 1'b1; saddr = sp_q; sp_n = sp_q - 8'd1;
						end
						ceu_pkg::IMP_PLP: begin
							sp_n = sp_q + 8'd1; saddr = sp_n;
							p_n = m;
							p_n[ceu_pkg::FLAG_B] = 1'b0;
							p_n[ceu_pkg::FLAG_U] = 1'b1;
						end
						ceu_pkg::IMP_PHA: begin
							wdata = a_q; wen = 1'b1; saddr = sp_q; sp_n = sp_q - 8'd1;
						end
						ceu_pkg::IMP_PLA: begin
							sp_n = sp_q + 8'd1; saddr = sp_n;
							a_n = m; nz_val = m; nz_en = 1'b1;
						end
						ceu_pkg::IMP_DEY: begin
							y_n = y_q - 8'd1; nz_val = y_n; nz_en = 1'b1;
						end
						ceu_pkg::IMP_TAY: begin
							y_n = a_q; nz_val = a_q; nz_en = 1'b1;
						end
						ceu_pkg::IMP_INY: begin
							y_n = y_q + 8'd1; nz_val = y_n; nz_en = 1'b1;
						end
						default: begin
							x_n = x_q + 8'd1; nz_val = x_n; nz_en = 1'b1;
						end
					endcase
				end else if (bbb == ceu_pkg::BBB_IMPL2) begin
					unique case (aaa)
						ceu_pkg::FLG_CLC: p_n[ceu_pkg::FLAG_C] = 1'b0;
						ceu_pkg::FLG_SEC: p_n[ceu_pkg::FLAG_C] = 1'b1;
						ceu_pkg::FLG_CLI: p_n[ceu_pkg::FLAG_I] = 1'b0;
						ceu_pkg::FLG_SEI: p_n[ceu_pkg::FLAG_I] = 1'b1;
						ceu_pkg::FLG_TYA: begin
							a_n = y_q; nz_val = y_q; nz_en = 1'b1;
						end
						ceu_pkg::FLG_CLV: p_n[ceu_pkg::FLAG_V] = 1'b0;
						ceu_pkg::FLG_CLD: p_n[ceu_pkg::FLAG_D] = 1'b0;
						default:          p_n[ceu_pkg::FLAG_D] = 1'b1;
					endcase
				end else begin
					case (aaa) inside
						ceu_pkg::AAA_BIT: begin
							if (bbb == ceu_pkg::BBB_ZP || bbb == ceu_pkg::BBB_ABS) begin
								p_n[ceu_pkg::FLAG_N] = m[7];
								p_n[ceu_pkg::FLAG_V] = m[6];
								p_n[ceu_pkg::FLAG_Z] = ((a_q & m) == 8'd0);
							end
						end
						ceu_pkg::AAA_STY: begin
							if (bbb inside {ceu_pkg::BBB_ZP, ceu_pkg::BBB_ABS,
									ceu_pkg::BBB_ZPX}) begin
								wdata = y_q; wen = 1'b1;
							end
						end
						ceu_pkg::AAA_LDY: begin
							if (bbb inside {ceu_pkg::BBB_IMM0, ceu_pkg::BBB_ZP,
									ceu_pkg::BBB_ABS, ceu_pkg::BBB_ZPX,
									ceu_pkg::BBB_ABSX}) begin
								y_n = m; nz_val = m; nz_en = 1'b1;
							end
						end
						ceu_pkg::AAA_CPY, ceu_pkg::AAA_CPX: begin
							if (bbb inside {ceu_pkg::BBB_IMM0, ceu_pkg::BBB_ZP,
									ceu_pkg::BBB_ABS}) begin
								p_n[ceu_pkg::FLAG_C] = diff[8];
								nz_val = diff[7:0]; nz_en = 1'b1;
							end
						end
						default: begin
							// brk, jmp and unused slots: no operation
						end
					endcase
				end
			end
			default: begin
				// illegal opcode column: no operation
			end
		endcase
		// common n and z update
		if (nz_en) begin
			p_n[ceu_pkg::FLAG_N] = nz_val[7];
			p_n[ceu_pkg::FLAG_Z] = (nz_val == 8'd0);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= 8'd0;
			x_q  <= 8'd0;
			y_q  <= 8'd0;
			sp_q <= ceu_pkg::SP_RESET;
			p_q  <= ceu_pkg::STATUS_RESET;
		end else if (advance) begin
			a_q  <= a_n;
			x_q  <= x_n;
			y_q  <= y_n;
			sp_q <= sp_n;
			p_q  <= p_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.write_data     <= wdata;
			result_q.write_enable   <= wen;
			result_q.stack_addr_low <= saddr;
			result_q.branch_taken   <= taken;
			result_q.acc_out        <= a_n;
			result_q.x_out          <= x_n;
			result_q.y_out          <= y_n;
			result_q.sp_out         <= sp_n;
			result_q.status_out     <= p_n;
		end
	end

	// an executed instruction always lands in the result register
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("executed instruction did not produce a result");

	// a shown result mirrors the register file it was computed into
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.acc_out == a_q) && (result_q.x_out == x_q) &&
			(result_q.y_out == y_q) && (result_q.sp_out == sp_q) &&
			(result_q.status_out == p_q))
		else $error("result register out of step with architectural state");

	// registers hold while a result waits
	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |=> $stable(a_q) && $stable(sp_q) && $stable(p_q))
		else $error("state changed while result stalled");

	// unused status bit stays set
	a_unused_flag_set: assert property (@(posedge clk) disable iff (!arst_n)
		p_q[ceu_pkg::FLAG_U])
		else $error("status bit 5 cleared");

	// a taken branch never writes memory
	a_branch_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.branch_taken |-> !result_q.write_enable)
		else $error("branch result with memory write");

endmodule
